@@ src/gea_pkg.sv @@
// Shared types and constants for the generational entity allocator.
package gea_pkg;

	localparam int HANDLE_W  = 32;
	localparam int OP_W      = 3;
	localparam int STATUS_W  = 2;
	localparam int RANGE_W   = 12;
	localparam int CFG_IDX_W = 2;

	localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
	localparam logic [OP_W-1:0] OP_MAKE   = 3'd2;
	localparam logic [OP_W-1:0] OP_LOOKUP = 3'd3;
	localparam logic [OP_W-1:0] OP_CHECK  = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_RANGE  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_BEYOND = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH   = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SP,
		ST_DA,
		ST_DB,
		ST_DC,
		ST_W1,
		ST_W2,
		ST_W3
	} state_t;

	typedef enum logic [1:0] {
		K_RECYCLE,
		K_DROP,
		K_MA_REV,
		K_MA_INS
	} kind_t;

endpackage

@@ src/generational_entity_allocator_unit.sv @@
// Generational entity allocator: sequencer around a sparse and a dense memory.
// A request runs from acceptance to its done strobe: a plain create ends in the
// idle state, lookup and check alive pass ST_SP and ST_DA, and a delete that drops
// an entry passes ST_SP through ST_W3. The sequence is set by dependent reads of
// the sparse and dense memories and by the single write port of each. One request
// is in work at a time. After reset the sparse memory is cleared one entry a cycle,
// with busy high; configuration writes are taken meanwhile. Results cannot stall.
module generational_entity_allocator_unit #(
	parameter int CAPACITY = 4096,
	parameter int ID_BITS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [gea_pkg::OP_W-1:0]           operation,
	input  logic [gea_pkg::HANDLE_W-1:0]       handle,
	input  logic                               cfg_we,
	input  logic [gea_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gea_pkg::RANGE_W-1:0]        cfg_data,
	output logic                               done,
	output logic [gea_pkg::HANDLE_W-1:0]       result_handle,
	output logic                               found,
	output logic [gea_pkg::STATUS_W-1:0]       status,
	output logic [$clog2(CAPACITY+1)-1:0]      live_count
);
	import gea_pkg::*;

	localparam int SLOT_W = $clog2(CAPACITY + 1);
	localparam int SP_AW  = $clog2(CAPACITY);
	localparam logic [32:0] ID_MASK33 = (33'd1 << ID_BITS) - 33'd1;
	localparam logic [32:0] GEN_INC   = 33'd1 << ID_BITS;
	localparam logic [32:0] CAP33     = 33'(CAPACITY);
	localparam logic [SLOT_W-1:0] CAP_S = SLOT_W'(CAPACITY);
	localparam logic [SLOT_W-1:0] ONE_S = SLOT_W'(1);
	localparam logic [SP_AW-1:0] SP_LAST = SP_AW'(CAPACITY - 1);

	function automatic logic [32:0] id_of(input logic [HANDLE_W-1:0] v);
		return {1'b0, v} & ID_MASK33;
	endfunction

	function automatic logic [SP_AW-1:0] sp_idx(input logic [HANDLE_W-1:0] v);
		logic [32:0] t;
		t = id_of(v);
		return t[SP_AW-1:0];
	endfunction

	function automatic logic id_ok(input logic [HANDLE_W-1:0] v);
		return id_of(v) < CAP33;
	endfunction

	function automatic logic [HANDLE_W-1:0] bump(input logic [HANDLE_W-1:0] v);
		logic [32:0] t;
		t = ({1'b0, v} & ~ID_MASK33) + GEN_INC;
		return (t[31:0] & ~ID_MASK33[31:0]) | (v & ID_MASK33[31:0]);
	endfunction

	logic [HANDLE_W-1:0] d_mem [0:CAPACITY];

	state_t state_q, state_d;
	kind_t  kind_q, kind_d;
	logic [OP_W-1:0]     op_q, op_d;
	logic [HANDLE_W-1:0] h_q, h_d, a_q, a_d, b_q, b_d, c_q, c_d;
	logic [SLOT_W-1:0]   s_q, s_d, at_q, at_d, du_q, du_d, nf_q, nf_d;
	logic [SP_AW-1:0]    clr_q, clr_d;
	logic                ren_q;
	logic [RANGE_W-1:0]  lo_q, hi_q;
	logic                done_q, done_d, found_q, found_d;
	logic [HANDLE_W-1:0] res_q, res_d;
	logic [STATUS_W-1:0] stat_q, stat_d;
	logic [SLOT_W-1:0]   lc_q;

	logic [SLOT_W-1:0]   sp_rd_q;
	logic [HANDLE_W-1:0] d_rd_q;
	logic                sp_we, d_we;
	logic [SP_AW-1:0]    sp_waddr, sp_raddr;
	logic [SLOT_W-1:0]   sp_wdata, d_waddr, d_raddr;
	logic [HANDLE_W-1:0] d_wdata;
	logic                fin;
	logic                fresh_bad, nf_in, h_in;

	logic [SLOT_W-1:0] sp_store [0:CAPACITY-1];

	always_ff @(posedge clk) begin
		if (sp_we)
			sp_store[sp_waddr] <= sp_wdata;
		sp_rd_q <= sp_store[sp_raddr];
	end

	always_ff @(posedge clk) begin
		if (d_we)
			d_mem[d_waddr] <= d_wdata;
		d_rd_q <= d_mem[d_raddr];
	end

	assign fresh_bad = (nf_q >= CAP_S) || (33'(nf_q) > ID_MASK33) || (du_q >= CAP_S);
	assign nf_in = (33'(nf_q) >= 33'(lo_q)) && (33'(nf_q) <= 33'(hi_q));
	assign h_in  = (id_of(h_q) >= 33'(lo_q)) && (id_of(h_q) <= 33'(hi_q));

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		op_d    = op_q;
		h_d     = h_q;
		a_d     = a_q;
		b_d     = b_q;
		c_d     = c_q;
		s_d     = s_q;
		at_d    = at_q;
		du_d    = du_q;
		nf_d    = nf_q;
		clr_d   = clr_q;
		res_d   = '0;
		found_d = 1'b0;
		stat_d  = STAT_OK;
		fin     = 1'b0;
		sp_we    = 1'b0;
		sp_waddr = sp_idx(h_q);
		sp_wdata = '0;
		sp_raddr = sp_idx(h_q);
		d_we     = 1'b0;
		d_waddr  = '0;
		d_wdata  = '0;
		d_raddr  = '0;
		case (state_q)
			ST_CLEAR: begin
				sp_we    = 1'b1;
				sp_waddr = clr_q;
				clr_d    = clr_q + SP_AW'(1);
				if (clr_q == SP_LAST)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					op_d = operation;
					h_d  = handle;
					case (operation)
						OP_CREATE: begin
							if (at_q < du_q) begin
								d_raddr = at_q + ONE_S;
								state_d = ST_DA;
							end else if (fresh_bad) begin
								stat_d = STAT_FULL;
								fin    = 1'b1;
							end else if (ren_q && !nf_in) begin
								stat_d = STAT_RANGE;
								fin    = 1'b1;
							end else begin
								d_we     = 1'b1;
								d_waddr  = du_q + ONE_S;
								d_wdata  = HANDLE_W'(nf_q);
								sp_we    = 1'b1;
								sp_waddr = sp_idx(HANDLE_W'(nf_q));
								sp_wdata = at_q + ONE_S;
								at_d     = at_q + ONE_S;
								du_d     = du_q + ONE_S;
								nf_d     = nf_q + ONE_S;
								res_d    = HANDLE_W'(nf_q);
								fin      = 1'b1;
							end
						end
						OP_DELETE, OP_MAKE, OP_LOOKUP, OP_CHECK: begin
							if (!id_ok(handle)) begin
								stat_d = STAT_BEYOND;
								fin    = 1'b1;
							end else begin
								sp_raddr = sp_idx(handle);
								state_d  = ST_SP;
							end
						end
						default: fin = 1'b1;
					endcase
				end
			end
			ST_SP: begin
				s_d = sp_rd_q;
				case (op_q)
					OP_DELETE, OP_LOOKUP, OP_CHECK: begin
						if (sp_rd_q != '0 && sp_rd_q <= at_q) begin
							d_raddr = sp_rd_q;
							state_d = ST_DA;
						end else begin
							fin = 1'b1;
						end
					end
					OP_MAKE: begin
						if (sp_rd_q != '0) begin
							if (sp_rd_q <= at_q) begin
								d_we    = 1'b1;
								d_waddr = sp_rd_q;
								d_wdata = h_q;
								fin     = 1'b1;
							end else if (sp_rd_q != at_q + ONE_S) begin
								d_raddr = at_q + ONE_S;
								kind_d  = K_MA_REV;
								state_d = ST_DA;
							end else begin
								d_we    = 1'b1;
								d_waddr = at_q + ONE_S;
								d_wdata = h_q;
								at_d    = at_q + ONE_S;
								fin     = 1'b1;
							end
						end else if (du_q >= CAP_S) begin
							stat_d = STAT_FULL;
							fin    = 1'b1;
						end else if (at_q >= du_q) begin
							d_we     = 1'b1;
							d_waddr  = du_q + ONE_S;
							d_wdata  = h_q;
							sp_we    = 1'b1;
							sp_wdata = at_q + ONE_S;
							at_d     = at_q + ONE_S;
							du_d     = du_q + ONE_S;
							fin      = 1'b1;
						end else begin
							d_raddr = at_q + ONE_S;
							kind_d  = K_MA_INS;
							state_d = ST_DA;
						end
					end
					default: fin = 1'b1;
				endcase
			end
			ST_DA: begin
				a_d = d_rd_q;
				case (op_q)
					OP_CREATE: begin
						at_d  = at_q + ONE_S;
						res_d = d_rd_q;
						fin   = 1'b1;
					end
					OP_LOOKUP: begin
						res_d   = d_rd_q;
						found_d = 1'b1;
						fin     = 1'b1;
					end
					OP_CHECK: begin
						found_d = (d_rd_q == h_q);
						fin     = 1'b1;
					end
					OP_DELETE: begin
						if (d_rd_q != h_q) begin
							fin = 1'b1;
						end else if (ren_q && !h_in) begin
							kind_d  = K_DROP;
							d_raddr = at_q;
							state_d = ST_DB;
						end else if (s_q != at_q) begin
							kind_d  = K_RECYCLE;
							d_raddr = at_q;
							state_d = ST_DB;
						end else begin
							d_we    = 1'b1;
							d_waddr = at_q;
							d_wdata = bump(h_q);
							at_d    = at_q - ONE_S;
							fin     = 1'b1;
						end
					end
					OP_MAKE: state_d = ST_W1;
					default: fin = 1'b1;
				endcase
			end
			ST_DB: begin
				b_d = d_rd_q;
				if (kind_q == K_DROP) begin
					d_raddr = du_q;
					state_d = ST_DC;
				end else begin
					state_d = ST_W1;
				end
			end
			ST_DC: begin
				c_d     = d_rd_q;
				state_d = ST_W1;
			end
			ST_W1: begin
				state_d = ST_W2;
				case (kind_q)
					K_RECYCLE, K_DROP: begin
						if (s_q != at_q) begin
							d_we     = 1'b1;
							d_waddr  = s_q;
							d_wdata  = b_q;
							sp_we    = id_ok(b_q);
							sp_waddr = sp_idx(b_q);
							sp_wdata = s_q;
						end
					end
					K_MA_REV: begin
						d_we     = 1'b1;
						d_waddr  = s_q;
						d_wdata  = a_q;
						sp_we    = id_ok(a_q);
						sp_waddr = sp_idx(a_q);
						sp_wdata = s_q;
					end
					default: begin
						d_we     = 1'b1;
						d_waddr  = du_q + ONE_S;
						d_wdata  = a_q;
						sp_we    = id_ok(a_q);
						sp_waddr = sp_idx(a_q);
						sp_wdata = du_q + ONE_S;
					end
				endcase
			end
			ST_W2: begin
				case (kind_q)
					K_RECYCLE: begin
						d_we     = 1'b1;
						d_waddr  = at_q;
						d_wdata  = bump(h_q);
						sp_we    = 1'b1;
						sp_wdata = at_q;
						at_d     = at_q - ONE_S;
						fin      = 1'b1;
					end
					K_DROP: begin
						if (at_q != du_q) begin
							d_we     = 1'b1;
							d_waddr  = at_q;
							d_wdata  = c_q;
							sp_we    = id_ok(c_q);
							sp_waddr = sp_idx(c_q);
							sp_wdata = at_q;
						end
						state_d = ST_W3;
					end
					K_MA_REV: begin
						d_we     = 1'b1;
						d_waddr  = at_q + ONE_S;
						d_wdata  = h_q;
						sp_we    = 1'b1;
						sp_wdata = at_q + ONE_S;
						at_d     = at_q + ONE_S;
						fin      = 1'b1;
					end
					default: begin
						d_we     = 1'b1;
						d_waddr  = at_q + ONE_S;
						d_wdata  = h_q;
						sp_we    = 1'b1;
						sp_wdata = at_q + ONE_S;
						at_d     = at_q + ONE_S;
						du_d     = du_q + ONE_S;
						fin      = 1'b1;
					end
				endcase
			end
			ST_W3: begin
				sp_we = 1'b1;
				at_d  = at_q - ONE_S;
				du_d  = du_q - ONE_S;
				fin   = 1'b1;
			end
			default: state_d = ST_IDLE;
		endcase
		if (fin)
			state_d = ST_IDLE;
		done_d = fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			at_q   <= '0;
			du_q   <= '0;
			nf_q   <= ONE_S;
			done_q <= 1'b0;
			ren_q  <= 1'b0;
			lo_q   <= '0;
			hi_q   <= '1;
			kind_q <= K_RECYCLE;
		end else begin
			clr_q  <= clr_d;
			at_q   <= at_d;
			du_q   <= du_d;
			nf_q   <= nf_d;
			done_q <= done_d;
			kind_q <= kind_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_RANGE_ENABLE: ren_q <= cfg_data[0];
					REG_RANGE_LOW:    lo_q  <= cfg_data;
					REG_RANGE_HIGH:   hi_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q    <= op_d;
		h_q     <= h_d;
		a_q     <= a_d;
		b_q     <= b_d;
		c_q     <= c_d;
		s_q     <= s_d;
		res_q   <= res_d;
		found_q <= found_d;
		stat_q  <= stat_d;
		lc_q    <= at_d;
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign result_handle = res_q;
	assign found         = found_q;
	assign status        = stat_q;
	assign live_count    = lc_q;

`ifndef SYNTHESIS
	a_alive_within_used: assert property (@(posedge clk) disable iff (!arst_n)
		at_q <= du_q)
		else $error("Alive count exceeds used dense slots.");

	a_used_within_cap: assert property (@(posedge clk) disable iff (!arst_n)
		du_q <= CAP_S && nf_q != '0)
		else $error("Dense usage or fresh id out of bounds.");

	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy) || $past(start))
		else $error("Done strobe without a request.");

	a_no_done_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !done_q)
		else $error("Done strobe during the clearing pass.");
`endif

endmodule

@@ test/gea_checker.sv @@
// Checker for the allocator: mirrors the sparse set and compares every result.
module gea_checker
	import gea_pkg::*;
(
	input  logic                  clk,
	input  logic                  start,
	input  logic                  busy,
	input  logic [OP_W-1:0]       operation,
	input  logic [HANDLE_W-1:0]   handle,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [RANGE_W-1:0]    cfg_data,
	input  logic                  done,
	input  logic [HANDLE_W-1:0]   result_handle,
	input  logic                  found,
	input  logic [STATUS_W-1:0]   status,
	input  logic [12:0]           live_count,
	output int                    fails,
	output int                    pending
);

	localparam int CAP = 4096;

	typedef struct packed {
		logic [HANDLE_W-1:0] hnd;
		logic                hit;
		logic [STATUS_W-1:0] st;
		logic [12:0]         count;
	} outcome_t;

	logic [12:0]         slot_of_id [0:CAP-1];
	logic [HANDLE_W-1:0] slot_handle [0:CAP];
	logic [12:0]         alive_n;
	logic [12:0]         used_n;
	logic [12:0]         fresh_id;
	logic                limit_on;
	logic [RANGE_W-1:0]  limit_lo;
	logic [RANGE_W-1:0]  limit_hi;
	outcome_t            pending_outcomes [$];

	initial begin
		for (int i = 0; i < CAP; i++) slot_of_id[i] = '0;
		for (int i = 0; i <= CAP; i++) slot_handle[i] = '0;
		alive_n = '0;
		used_n = '0;
		fresh_id = 13'd1;
		limit_on = 1'b0;
		limit_lo = '0;
		limit_hi = 12'd4095;
	end

	function automatic bit id_allowed(input int unsigned id);
		return id >= limit_lo && id <= limit_hi;
	endfunction

	function automatic bit handle_live(input logic [HANDLE_W-1:0] h);
		logic [12:0] s;
		s = slot_of_id[h[15:0]];
		return s != 0 && s <= alive_n && slot_handle[s] == h;
	endfunction

	function automatic void retire(input logic [HANDLE_W-1:0] h, input logic [12:0] s);
		logic [HANDLE_W-1:0] other;
		if (s != alive_n) begin
			other = slot_handle[alive_n];
			slot_handle[s] = other;
			slot_of_id[other[15:0]] = s;
			slot_of_id[h[15:0]] = alive_n;
		end
		slot_handle[alive_n] = {h[31:16] + 16'd1, h[15:0]};
		alive_n = alive_n - 13'd1;
	endfunction

	function automatic void evict(input logic [HANDLE_W-1:0] h, input logic [12:0] s);
		logic [12:0]         la;
		logic [HANDLE_W-1:0] la_h;
		logic [HANDLE_W-1:0] end_h;
		la = alive_n;
		la_h = slot_handle[la];
		end_h = slot_handle[used_n];
		if (s != la) begin
			slot_handle[s] = la_h;
			slot_of_id[la_h[15:0]] = s;
		end
		if (la != used_n) begin
			slot_handle[la] = end_h;
			slot_of_id[end_h[15:0]] = la;
		end
		slot_of_id[h[15:0]] = '0;
		used_n = used_n - 13'd1;
		alive_n = alive_n - 13'd1;
	endfunction

	function automatic logic [STATUS_W-1:0] revive(input logic [HANDLE_W-1:0] h);
		logic [12:0]         s;
		logic [12:0]         nxt;
		logic [HANDLE_W-1:0] spare_h;
		s = slot_of_id[h[15:0]];
		if (s != 0) begin
			if (s <= alive_n) begin
				slot_handle[s] = h;
				return STAT_OK;
			end
			alive_n = alive_n + 13'd1;
			nxt = alive_n;
			if (s != nxt) begin
				spare_h = slot_handle[nxt];
				slot_handle[s] = spare_h;
				slot_of_id[spare_h[15:0]] = s;
				slot_of_id[h[15:0]] = nxt;
			end
			slot_handle[nxt] = h;
			return STAT_OK;
		end
		if (used_n >= CAP) return STAT_FULL;
		if (alive_n >= used_n) begin
			used_n = used_n + 13'd1;
			slot_handle[used_n] = h;
			alive_n = alive_n + 13'd1;
			slot_of_id[h[15:0]] = alive_n;
		end else begin
			alive_n = alive_n + 13'd1;
			nxt = alive_n;
			spare_h = slot_handle[nxt];
			used_n = used_n + 13'd1;
			slot_handle[used_n] = spare_h;
			slot_of_id[spare_h[15:0]] = used_n;
			slot_handle[nxt] = h;
			slot_of_id[h[15:0]] = nxt;
		end
		return STAT_OK;
	endfunction

	function automatic outcome_t predict_request(input logic [OP_W-1:0] op,
			input logic [HANDLE_W-1:0] h);
		outcome_t    r;
		logic [12:0] s;
		r = '0;
		if (op == OP_CREATE) begin
			if (alive_n < used_n) begin
				alive_n = alive_n + 13'd1;
				r.hnd = slot_handle[alive_n];
			end else if (fresh_id >= CAP || used_n >= CAP) begin
				r.st = STAT_FULL;
			end else if (limit_on && !id_allowed(fresh_id)) begin
				r.st = STAT_RANGE;
			end else begin
				used_n = used_n + 13'd1;
				slot_handle[used_n] = {19'd0, fresh_id};
				alive_n = alive_n + 13'd1;
				slot_of_id[fresh_id] = alive_n;
				r.hnd = {19'd0, fresh_id};
				fresh_id = fresh_id + 13'd1;
			end
		end else if (op <= OP_CHECK && h[15:0] >= CAP) begin
			r.st = STAT_BEYOND;
		end else if (op == OP_DELETE) begin
			if (handle_live(h)) begin
				s = slot_of_id[h[15:0]];
				if (limit_on && !id_allowed(h[15:0])) evict(h, s);
				else retire(h, s);
			end
		end else if (op == OP_MAKE) begin
			r.st = revive(h);
		end else if (op == OP_LOOKUP) begin
			s = slot_of_id[h[15:0]];
			if (s != 0 && s <= alive_n) begin
				r.hnd = slot_handle[s];
				r.hit = 1'b1;
			end
		end else if (op == OP_CHECK) begin
			r.hit = handle_live(h);
		end
		r.count = alive_n;
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
		$display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
		fails++;
	endtask

	always @(posedge clk) begin
		outcome_t want;
		if (done) begin
			if (pending_outcomes.size() == 0) begin
				report("unrequested result", 32'd0, result_handle);
			end else begin
				want = pending_outcomes.pop_front();
				if (result_handle !== want.hnd) report("result_handle", want.hnd, result_handle);
				if (found !== want.hit) report("found", 32'(want.hit), 32'(found));
				if (status !== want.st) report("status", 32'(want.st), 32'(status));
				if (live_count !== want.count)
					report("live_count", 32'(want.count), 32'(live_count));
			end
		end
		if (cfg_we) begin
			case (cfg_index)
				REG_RANGE_ENABLE: limit_on = cfg_data[0];
				REG_RANGE_LOW:    limit_lo = cfg_data;
				REG_RANGE_HIGH:   limit_hi = cfg_data;
				default: ;
			endcase
		end
		if (start && !busy)
			pending_outcomes.insert(pending_outcomes.size(), predict_request(operation, handle));
		pending <= pending_outcomes.size();
	end

endmodule

@@ test/tb.sv @@
// Testbench top: clock, reset, request stimulus and the final verdict.
module tb;
	import gea_pkg::*;

	localparam int LIMIT = 3000000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [OP_W-1:0]      operation;
	logic [HANDLE_W-1:0]  handle;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [RANGE_W-1:0]   cfg_data;
	logic                 done;
	logic [HANDLE_W-1:0]  result_handle;
	logic                 found;
	logic [STATUS_W-1:0]  status;
	logic [12:0]          live_count;
	int                   fails;
	int                   pending;
	int                   cycles;
	bit                   quiet;
	logic [HANDLE_W-1:0]  recent [0:31];

	generational_entity_allocator_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .handle(handle),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .result_handle(result_handle), .found(found),
		.status(status), .live_count(live_count)
	);

	gea_checker check_unit (
		.clk(clk), .start(start), .busy(busy), .operation(operation), .handle(handle),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .result_handle(result_handle), .found(found),
		.status(status), .live_count(live_count), .fails(fails), .pending(pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		cycles = 0;
		for (int i = 0; i < 32; i++) recent[i] = i + 1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (done && result_handle != 0) recent[$urandom_range(0, 31)] <= result_handle;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] h);
		int pick;
		int gap;
		operation <= op;
		handle <= h;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pick = $urandom_range(0, 99);
		if (quiet) gap = 0;
		else if (pick < 70) gap = $urandom_range(0, 1);
		else if (pick < 95) gap = $urandom_range(2, 5);
		else gap = $urandom_range(10, 40);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_range(input logic en, input logic [11:0] lo, input logic [11:0] hi);
		cfg_we <= 1'b1;
		cfg_index <= REG_RANGE_ENABLE;
		cfg_data <= {11'd0, en};
		@(posedge clk);
		cfg_index <= REG_RANGE_LOW;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= REG_RANGE_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [HANDLE_W-1:0] pick_handle;
		logic [HANDLE_W-1:0] h;
		h = recent[$urandom_range(0, 31)];
		case ($urandom_range(0, 9))
			5: h[31:16] = h[31:16] + 16'd1;
			6: h = {14'd0, 2'($urandom_range(0, 3)), 10'd0, 6'($urandom_range(0, 63))};
			7: h = $urandom;
			8: h = {16'($urandom), 16'($urandom_range(4088, 4100))};
			9: h[31:16] = 16'($urandom);
			default: ;
		endcase
		return h;
	endfunction

	task automatic random_requests(input int n);
		int w;
		logic [OP_W-1:0] op;
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
			w = $urandom_range(0, 99);
			if (w < 28) op = OP_CREATE;
			else if (w < 52) op = OP_DELETE;
			else if (w < 64) op = OP_MAKE;
			else if (w < 79) op = OP_LOOKUP;
			else if (w < 96) op = OP_CHECK;
			else op = 3'($urandom_range(5, 7));
			send(op, pick_handle());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_CREATE;
		handle = '0;
		cfg_we = 1'b0;
		cfg_index = REG_RANGE_ENABLE;
		cfg_data = '0;
		quiet = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		write_range(1'b0, 12'd0, 12'd4095);

		send(OP_CREATE, 32'hFFFF_FFFF);
		send(OP_CREATE, 32'h0);
		send(OP_CREATE, 32'h0);
		send(OP_LOOKUP, 32'h1234_0001);
		send(OP_CHECK, 32'h0000_0001);
		send(OP_CHECK, 32'h0001_0001);
		send(OP_DELETE, 32'h0000_0001);
		send(OP_DELETE, 32'h0000_0001);
		send(OP_CREATE, 32'h0);
		send(OP_MAKE, 32'hFFFF_0064);
		send(OP_DELETE, 32'hFFFF_0064);
		send(OP_CHECK, 32'h0000_0064);
		send(OP_MAKE, 32'h0007_0064);
		send(OP_MAKE, 32'h0000_0000);
		send(OP_DELETE, 32'hFFFF_1000);
		send(OP_MAKE, 32'h0000_FFFF);
		send(OP_LOOKUP, 32'hFFFF_FFFF);
		send(OP_CHECK, 32'h0000_1000);
		send(3'd5, 32'hFFFF_FFFF);
		send(3'd6, 32'h0000_0002);
		send(3'd7, 32'h0);
		drain();
		write_range(1'b1, 12'd100, 12'd100);
		send(OP_CREATE, 32'h0);
		send(OP_DELETE, 32'h0000_0002);
		send(OP_CREATE, 32'h0);
		send(OP_DELETE, 32'h0000_0003);
		drain();

		write_range(1'b1, 12'd0, 12'd4095);
		random_requests(200);
		drain();
		write_range(1'b1, 12'd5, 12'd40);
		random_requests(200);
		drain();
		write_range(1'b1, 12'd30, 12'd10);
		random_requests(150);
		drain();
		write_range(1'b1, 12'($urandom), 12'($urandom));
		random_requests(150);
		drain();
		write_range(1'b0, 12'd4095, 12'd0);
		random_requests(200);
		drain();

		write_range(1'b0, 12'd0, 12'd4095);
		quiet = 1'b1;
		for (int i = 0; i < 150; i++) send(OP_CREATE, $urandom);
		quiet = 1'b0;
		send(OP_MAKE, 32'h0005_0FFF);
		drain();
		write_range(1'b1, 12'd0, 12'd2047);
		random_requests(150);
		drain();

		repeat (20) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/gea_pkg.sv
src/generational_entity_allocator_unit.sv
test/gea_checker.sv
test/tb.sv
